>>> hw/rtl/isrt_pkg.sv
// Shared constants and controller/datapath interface types for the insertion sorter.
package isrt_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int DATA_W        = 32;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load;     // latch incoming value, start insert at top of store
        logic set_ovf;  // store full, incoming value dropped
        logic ins_rd;   // read entry below insert position
        logic shift;    // move read entry up one place
        logic put;      // write value at insert position, bump count
        logic em_rd;    // read entry at emit index
        logic em_adv;   // step emit index
        logic clear;    // run done: empty store, drop overflow flag
    } isrt_cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic full;      // count at capacity
        logic cnt_zero;  // store empty
        logic ge;        // read entry >= held value (signed)
        logic k_one;     // insert position is 1
        logic em_last;   // emit index on final stored entry
        logic last;      // held item carried the last mark
        logic in_last;   // last mark on the input port
    } isrt_sts_t;

endpackage

>>> hw/rtl/insertion_sorter.sv
// Top level of the insertion sorter: controller plus store datapath.
//
//   channel | ports                                                 | direction
//   --------+-------------------------------------------------------+----------
//   input   | s_valid s_ready s_value s_last                        | in
//   result  | m_valid m_ready m_sorted_value m_last_res m_overflow  | out
//
// Insertion: an accepted item walks down from the top of the store, reading
//   the entry below its insert position and shifting it up while it is >= the
//   item, then writes the item; a dropped item (store full) is not stored.
// Emission: per result, a memory read, then an output hold until m_ready.
// Reset (aresetn low, synchronous) clears count and overflow flag, not the store.
// s_ready stays low through each insertion and through the emission of a run.
module insertion_sorter #(
    parameter int MAX_ITEMS = isrt_pkg::MAX_ITEMS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [isrt_pkg::DATA_W-1:0]  s_value,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [isrt_pkg::DATA_W-1:0]  m_sorted_value,
    output logic                                m_last_res,
    output logic                                m_overflow
);

    isrt_pkg::isrt_cmd_t cmd;
    isrt_pkg::isrt_sts_t sts;

    // sequencing of insert walk and emit run
    isrt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // sorted store, count, overflow and the registered read word that
    // doubles as the result register
    isrt_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_value        (s_value),
        .s_last         (s_last),
        .cmd            (cmd),
        .sts            (sts),
        .m_sorted_value (m_sorted_value),
        .m_last_res     (m_last_res),
        .m_overflow     (m_overflow)
    );

endmodule

>>> hw/rtl/isrt_datapath.sv
// Datapath: sorted store memory, count, overflow flag, insert and emit indexes.
module isrt_datapath #(
    parameter int MAX_ITEMS = isrt_pkg::MAX_ITEMS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic signed [isrt_pkg::DATA_W-1:0]      s_value,
    input  logic                                    s_last,
    input  isrt_pkg::isrt_cmd_t                     cmd,
    output isrt_pkg::isrt_sts_t                     sts,
    output logic signed [isrt_pkg::DATA_W-1:0]      m_sorted_value,
    output logic                                    m_last_res,
    output logic                                    m_overflow
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic signed [isrt_pkg::DATA_W-1:0] mem [MAX_ITEMS];

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] em_idx_reg, em_idx_next;
    logic signed [isrt_pkg::DATA_W-1:0] value_reg;
    logic          last_reg;
    logic signed [isrt_pkg::DATA_W-1:0] rdata_reg;

    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic signed [isrt_pkg::DATA_W-1:0] wr_data;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;

    assign wr_en   = cmd.shift | cmd.put;
    assign wr_addr = k_reg;
    assign wr_data = cmd.shift ? rdata_reg : value_reg;
    assign rd_en   = cmd.ins_rd | cmd.em_rd;
    assign rd_addr = cmd.em_rd ? em_idx_reg : (k_reg - AW'(1));

    // single write port, single registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_value;
            last_reg  <= s_last;
        end
    end

    always_comb begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        k_next      = k_reg;
        em_idx_next = em_idx_reg;
        if (cmd.load)    k_next = count_reg[AW-1:0];
        if (cmd.shift)   k_next = k_reg - AW'(1);
        if (cmd.put)     count_next = count_reg + CW'(1);
        if (cmd.set_ovf) ovf_next = 1'b1;
        if (cmd.em_adv)  em_idx_next = em_idx_reg + AW'(1);
        if (cmd.clear) begin
            count_next  = '0;
            ovf_next    = 1'b0;
            em_idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            k_reg      <= '0;
            em_idx_reg <= '0;
        end else begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            k_reg      <= k_next;
            em_idx_reg <= em_idx_next;
        end
    end

    always_comb begin
        sts.full     = (count_reg == CW'(MAX_ITEMS));
        sts.cnt_zero = (count_reg == '0);
        sts.ge       = (rdata_reg >= value_reg);
        sts.k_one    = (k_reg == AW'(1));
        sts.em_last  = ((CW'(em_idx_reg) + CW'(1)) == count_reg);
        sts.last     = last_reg;
        sts.in_last  = s_last;
    end

    assign m_sorted_value = rdata_reg;
    assign m_last_res     = sts.em_last;
    assign m_overflow     = ovf_reg;

endmodule

>>> hw/rtl/isrt_ctrl.sv
// Controller state machine: input handshake, insertion walk, emit sequence.
module isrt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  isrt_pkg::isrt_sts_t  sts,
    output isrt_pkg::isrt_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS_RD  = 3'd1;
    localparam logic [2:0] ST_INS_CMP = 3'd2;
    localparam logic [2:0] ST_INS_PUT = 3'd3;
    localparam logic [2:0] ST_EM_RD   = 3'd4;
    localparam logic [2:0] ST_EM_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EM_OUT);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (sts.full) begin
                        cmd.set_ovf = 1'b1;
                        state_next  = sts.in_last ? ST_EM_RD : ST_IDLE;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = sts.cnt_zero ? ST_INS_PUT : ST_INS_RD;
                    end
                end
            end
            ST_INS_RD: begin
                cmd.ins_rd = 1'b1;
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                if (sts.ge) begin
                    cmd.shift  = 1'b1;
                    state_next = sts.k_one ? ST_INS_PUT : ST_INS_RD;
                end else begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                cmd.put    = 1'b1;
                state_next = sts.last ? ST_EM_RD : ST_IDLE;
            end
            ST_EM_RD: begin
                cmd.em_rd  = 1'b1;
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (m_ready) begin
                    if (sts.em_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.em_adv = 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/isrt_checker.sv
// Port-level checker for the insertion sorter, bound to the top level.
module isrt_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic signed [isrt_pkg::DATA_W-1:0]  s_value,
    input logic                                s_last,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [isrt_pkg::DATA_W-1:0]  m_sorted_value,
    input logic                                m_last_res,
    input logic                                m_overflow
);

    // input item held while it waits
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_value) && $stable(s_last))
        else $error("input item changed while waiting");

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sorted_value)
            && $stable(m_last_res) && $stable(m_overflow))
        else $error("result changed while stalled");

    // no input taken while a run is being emitted
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready during emission");

    // a last-marked item always starts a run, so input closes
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input reopened after last item");

    // run ends after the final result
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_res |=> !m_valid && s_ready)
        else $error("emission continued past final result");

endmodule

bind insertion_sorter isrt_checker u_isrt_checker (.*);

>>> verif/insertion_sorter_tb.sv
// Self-checking testbench for insertion_sorter: bursty input, stalling output, run-level checks.
module insertion_sorter_tb;

    localparam int CAPACITY    = isrt_pkg::MAX_ITEMS_DEF;
    localparam int ITEM_BUDGET = 420;   // stored values to aim for, dropped ones excluded
    localparam int HOLD_CYCLES = 400;   // one long output back-pressure window
    localparam int DRAIN_WAIT  = 40;    // quiet cycles at the end to catch stray results

    typedef logic signed [isrt_pkg::DATA_W-1:0] q16_t;

    // One pending input item.
    typedef struct {
        q16_t value;
        bit   last;
    } load_item_t;

    // One expected sorted result.
    typedef struct {
        q16_t value;
        bit   last_res;
        bit   overflow;
    } sorted_result_t;

    typedef enum int {VAL_FULL, VAL_NARROW, VAL_FIXED, VAL_EDGE} value_mode_e;
    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_SPARSE} ready_mode_e;

    logic aclk;
    logic aresetn  = 1'b0;
    logic s_valid  = 1'b0;
    logic s_ready;
    q16_t s_value  = '0;
    logic s_last   = 1'b0;
    logic m_valid;
    logic m_ready  = 1'b0;
    q16_t m_sorted_value;
    logic m_last_res;
    logic m_overflow;

    insertion_sorter #(.MAX_ITEMS(CAPACITY)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_res     (m_last_res),
        .m_overflow     (m_overflow)
    );

    // Stimulus and expectations.
    load_item_t     load_queue[$];
    sorted_result_t expected_sorted[$];

    // Shadow of the sorter state: ascending store, fill count, dropped-value flag.
    q16_t        shadow_store [CAPACITY];
    int unsigned shadow_count = 0;
    bit          shadow_dropped = 1'b0;

    int unsigned items_accepted = 0;
    int unsigned runs_done      = 0;
    int unsigned runs_dropped   = 0;
    int unsigned full_runs      = 0;
    int unsigned results_seen   = 0;
    int unsigned errors         = 0;

    // ------------------------------------------------------------------
    // Clock and reset: reset held low at the start, then released for good.
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Run ceiling, far above the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAIL insertion_sorter");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sorter prediction. Called once per accepted item. A value that meets
    // an equal stored entry goes below it, which for equal values means the
    // same ordering either way, so only the value sequence matters. A value
    // arriving on a full store is dropped and flags the whole run, and that
    // holds for the last-marked value as well.
    // ------------------------------------------------------------------
    task automatic insert_and_flush(input q16_t v, input bit lst);
        int k;
        sorted_result_t r;
        if (shadow_count == CAPACITY) begin
            shadow_dropped = 1'b1;
        end else begin
            k = shadow_count;
            while (k > 0 && shadow_store[k-1] >= v) begin
                shadow_store[k] = shadow_store[k-1];
                k--;
            end
            shadow_store[k] = v;
            shadow_count++;
        end
        if (lst) begin
            // a run is never empty: either this value landed or the store is full
            for (int i = 0; i < shadow_count; i++) begin
                r.value    = shadow_store[i];
                r.last_res = (i == shadow_count - 1);
                r.overflow = shadow_dropped;
                expected_sorted.push_back(r);
            end
            runs_done++;
            if (shadow_dropped) runs_dropped++;
            if (shadow_count == CAPACITY) full_runs++;
            shadow_count   = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_item(input q16_t v, input bit lst);
        load_item_t it;
        it.value = v;
        it.last  = lst;
        load_queue.push_back(it);
    endtask

    function automatic q16_t pick_value(input value_mode_e mode);
        q16_t v;
        case (mode)
            VAL_FULL: begin
                v = $urandom;
            end
            VAL_NARROW: begin
                // tight range so equal values pile up in one run
                v = int'($urandom_range(0, 8)) - 4;
            end
            VAL_FIXED: begin
                // plausible Q16.16 numbers: small integer part, any fraction
                v = {16'(int'($urandom_range(0, 200)) - 100), 16'($urandom_range(0, 65535))};
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh8000_0001;
                    2: v = 32'sh7FFF_FFFF;
                    3: v = 32'sh7FFF_FFFE;
                    4: v = '0;
                    default: v = -1;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic queue_random_set(input int n, input value_mode_e mode);
        for (int i = 0; i < n; i++)
            push_item(pick_value(mode), i == n - 1);
    endtask

    // ------------------------------------------------------------------
    // Item list: a directed opening, then random sets of mostly small size.
    // ------------------------------------------------------------------
    initial begin : fill_items
        int stored;
        int n;
        int kind;
        value_mode_e mode;

        // Single-value run at the most negative value.
        push_item(32'sh8000_0000, 1'b1);
        // Both extremes, zero twice, -1 and +1 in scrambled order.
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item(32'sh8000_0000, 1'b0);
        push_item(0, 1'b0);
        push_item(-1, 1'b0);
        push_item(1, 1'b0);
        push_item(0, 1'b1);
        // Alternating bit patterns, a repeat, and whole Q16.16 numbers.
        push_item(32'sh5555_5555, 1'b0);
        push_item(32'shAAAA_AAAA, 1'b0);
        push_item(32'shAAAA_AAAA, 1'b0);
        push_item(32'sh7FFF_0000, 1'b0);
        push_item(32'sh0001_0000, 1'b1);
        // Descending input: every insertion shifts the whole store.
        for (int i = 5; i >= 1; i--) push_item(i <<< 16, i == 1);
        // Descending negative values shift the whole store; the positive last one shifts nothing.
        for (int i = 1; i <= 4; i++) push_item(-(i <<< 16) + (i * 16'h4000), 1'b0);
        push_item(32'sh0000_8000, 1'b1);
        stored = 22;

        // Overfill: two values dropped, the last-marked one among them.
        queue_random_set(CAPACITY + 2, VAL_FULL);
        // Exactly full, nothing dropped.
        queue_random_set(CAPACITY, VAL_FIXED);
        stored += 2 * CAPACITY;

        while (stored < ITEM_BUDGET) begin
            kind = $urandom_range(0, 19);
            if (kind == 0)      n = CAPACITY;
            else if (kind == 1) n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            else                n = $urandom_range(1, 12);
            mode = value_mode_e'($urandom_range(0, 3));
            queue_random_set(n, mode);
            stored += (n > CAPACITY) ? CAPACITY : n;
        end
    end

    // ------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps. A
    // presented item holds until accepted; a new one is loaded on the same
    // edge that takes the previous one, so back-to-back streaming happens.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    load_item_t  next_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_value <= '0;
            s_last  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                insert_and_flush(s_value, s_last);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (load_queue.size() > 0) begin
                    next_item = load_queue.pop_front();
                    s_valid <= 1'b1;
                    s_value <= next_item.value;
                    s_last  <= next_item.last;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        // a quarter of the bursts run straight into the next
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: m_ready follows a mode that is re-picked at random
    // times. Once, after the first 30 results, it holds off for a long
    // stretch in the middle of an emission so the input side backs up.
    // ------------------------------------------------------------------
    ready_mode_e ready_mode = RDY_ALWAYS;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    bit          held_once  = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!held_once && m_valid && results_seen >= 30) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = ready_mode_e'($urandom_range(0, 2));
                    mode_left  = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (ready_mode)
                    RDY_ALWAYS: m_ready <= 1'b1;
                    RDY_RANDOM: m_ready <= $urandom_range(0, 1);
                    default:    m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    sorted_result_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_sorted.size() == 0) begin
                $display("%0t: result with nothing expected: value=%0d last=%0b ovf=%0b",
                         $time, m_sorted_value, m_last_res, m_overflow);
                errors++;
            end else begin
                want = expected_sorted.pop_front();
                if (m_sorted_value !== want.value) begin
                    $display("%0t: sorted_value expected %0d (%h) got %0d (%h)", $time,
                             want.value, want.value, m_sorted_value, m_sorted_value);
                    errors++;
                end
                if (m_last_res !== want.last_res) begin
                    $display("%0t: last_res expected %0b got %0b",
                             $time, want.last_res, m_last_res);
                    errors++;
                end
                if (m_overflow !== want.overflow) begin
                    $display("%0t: overflow expected %0b got %0b",
                             $time, want.overflow, m_overflow);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run. Sampling on the falling edge keeps clear of the updates
    // made on the rising edge.
    // ------------------------------------------------------------------
    initial begin
        @(posedge aresetn);
        @(negedge aclk);
        while (load_queue.size() != 0 || s_valid) @(negedge aclk);
        while (expected_sorted.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (expected_sorted.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_sorted.size());
            errors++;
        end
        $display("Checked %0d sorted results from %0d runs fed by %0d items",
                 results_seen, runs_done, items_accepted);
        $display("Full-store runs: %0d, runs with dropped values: %0d, mismatches: %0d",
                 full_runs, runs_dropped, errors);
        if (errors == 0) begin
            $display("PASS insertion_sorter");
        end else begin
            $display("FAIL insertion_sorter");
        end
        $finish;
    end

endmodule
